FILE: hw/rtl/imhdk_pkg.sv
// Shared types and constants for the indexed min-heap with decrease-key.
`default_nettype none

package imhdk_pkg;

  localparam int KEY_IN_BITS = 32;
  localparam int AMOUNT_BITS = 31;
  localparam int HANDLE_BITS = 10;
  localparam int COUNT_BITS  = 11;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_DECREASE = 2'd1,
    MODE_EXTRACT  = 2'd2,
    MODE_PEEK     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOT_LIVE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP,
    S_LIVE,
    S_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_t;

  typedef enum logic {
    KOP_LOAD,
    KOP_DECREASE
  } key_op_t;

  typedef struct packed {
    mode_t                          mode;
    logic signed [KEY_IN_BITS-1:0]  key_value;
    logic        [AMOUNT_BITS-1:0]  decrease_amount;
    logic        [HANDLE_BITS-1:0]  handle;
  } req_t;

  typedef struct packed {
    logic signed [KEY_IN_BITS-1:0]  min_key;
    logic        [COUNT_BITS-1:0]   entry_count;
    status_t                        status;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/imhdk_entry_ram.sv
// Heap slot memory: key and handle per slot, one write port, two registered read ports.
`default_nettype none

module imhdk_entry_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 42,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_a,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/imhdk_map_ram.sv
// Handle-to-slot map memory: one write port, one registered read port.
`default_nettype none

module imhdk_map_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/imhdk_key_unit.sv
// Key arithmetic: saturate an incoming key into range, or decrease a stored key.
`default_nettype none

module imhdk_key_unit #(
  parameter int KEY_BITS = 32
) (
  input  wire imhdk_pkg::key_op_t                       op,
  input  wire logic signed [imhdk_pkg::KEY_IN_BITS-1:0] key_in,
  input  wire logic        [imhdk_pkg::AMOUNT_BITS-1:0] amount,
  input  wire logic signed [KEY_BITS-1:0]               stored_key,
  output logic signed      [KEY_BITS-1:0]               new_key
);

  import imhdk_pkg::*;

  localparam int DW = ((KEY_BITS > KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS) + 2;
  localparam logic signed [DW-1:0] KMAX =
    $signed({{(DW-KEY_BITS+1){1'b0}}, {(KEY_BITS-1){1'b1}}});
  localparam logic signed [DW-1:0] KMIN = ~KMAX;

  logic signed [DW-1:0] kin;
  logic signed [DW-1:0] kcur;
  logic signed [DW-1:0] amt_x;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] sat;
  logic signed [DW-1:0] res;

  assign kin   = DW'(key_in);
  assign kcur  = DW'(stored_key);
  assign amt_x = DW'(amount);
  assign diff  = kcur - amt_x;

  always_comb begin
    priority if (kin > KMAX) begin
      sat = KMAX;
    end else if (kin < KMIN) begin
      sat = KMIN;
    end else begin
      sat = kin;
    end
  end

  always_comb begin
    unique case (op)
      KOP_DECREASE: res = (diff < KMIN) ? KMIN : diff;
      default:      res = sat;
    endcase
  end

  assign new_key = KEY_BITS'(res);

endmodule

`default_nettype wire

FILE: hw/rtl/indexed_min_heap_decrease_key.sv
// Indexed binary min-heap with decrease-key: sequencer, slot memory and handle map.
// Order: insert/decrease check the handle in the map, then sift the entry up level by level;
//   extract moves the last entry to the root and sifts it down; peek and rejected items skip the sift.
// Throughput: one item at a time; each level of sift costs one slot-memory read
//   and one compare.
// Reset: rst (synchronous) empties the heap and clears the result valid flag; the memories
//   hold no reset and need no clearing pass.
`default_nettype none

module indexed_min_heap_decrease_key #(
  parameter int CAPACITY     = 1024,
  parameter int HANDLE_COUNT = 1024,
  parameter int KEY_BITS     = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire imhdk_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output imhdk_pkg::rsp_t      rsp
);

  import imhdk_pkg::*;

  // Slot index, occupancy and handle-map index widths.
  localparam int SW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int HW = $clog2(HANDLE_COUNT);
  localparam int EW = KEY_BITS + HANDLE_BITS;

  state_t state;
  state_t state_next;

  logic [OW-1:0]          occ;
  logic [SW-1:0]          cur;
  status_t                stat;
  mode_t                  mode_q;
  logic signed [KEY_IN_BITS-1:0] key_q;
  logic [AMOUNT_BITS-1:0] amt_q;
  logic [HANDLE_BITS-1:0] handle_q;
  // Entry being moved through the heap (hole-based sift, no explicit swaps).
  logic signed [KEY_BITS-1:0] ek;
  logic [HANDLE_BITS-1:0]     eh;
  logic signed [KEY_BITS-1:0] root_key;

  logic acc;
  logic h_ok;
  logic live;
  logic rsp_load;

  // Memory ports.
  logic           ent_we;
  logic [SW-1:0]  ent_wr_addr;
  logic [EW-1:0]  ent_wr_data;
  logic           ent_rd_en;
  logic [SW-1:0]  ent_rd_addr_a;
  logic [SW-1:0]  ent_rd_addr_b;
  logic [EW-1:0]  ent_rd_data_a;
  logic [EW-1:0]  ent_rd_data_b;
  logic           map_we;
  logic [HW-1:0]  map_wr_addr;
  logic [SW-1:0]  map_wr_data;
  logic           map_rd_en;
  logic [SW-1:0]  map_rd_data;

  // Decoded slot data.
  logic signed [KEY_BITS-1:0] a_key;
  logic signed [KEY_BITS-1:0] b_key;
  logic [HANDLE_BITS-1:0]     a_handle;
  logic [HANDLE_BITS-1:0]     b_handle;
  logic signed [KEY_BITS-1:0] c_key;
  logic [HANDLE_BITS-1:0]     c_handle;
  logic [EW-1:0]              c_data;

  // Tree navigation.
  logic [SW-1:0] parent;
  logic [SW+1:0] c_left;
  logic [SW+1:0] c_right;
  logic [SW+1:0] occ_x;
  logic          take_r;
  logic [SW-1:0] c_addr;

  logic signed [KEY_BITS-1:0] unit_key;
  key_op_t                    unit_op;
  logic signed [63:0]         root64;

  assign acc       = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  assign h_ok = 17'(req.handle) < 17'(HANDLE_COUNT);

  assign a_key    = ent_rd_data_a[HANDLE_BITS +: KEY_BITS];
  assign b_key    = ent_rd_data_b[HANDLE_BITS +: KEY_BITS];
  assign a_handle = ent_rd_data_a[HANDLE_BITS-1:0];
  assign b_handle = ent_rd_data_b[HANDLE_BITS-1:0];

  // Handle is live when its mapped slot is occupied and points back at it.
  assign live = (OW'(cur) < occ) && (a_handle == handle_q);

  assign parent  = SW'((cur - SW'(1)) >> 1);
  assign c_left  = {1'b0, cur, 1'b1};
  assign c_right = c_left + (SW+2)'(1);
  assign occ_x   = (SW+2)'(occ);

  // Take the right child only when it exists and is strictly smaller.
  assign take_r   = (c_right < occ_x) && (b_key < a_key);
  assign c_key    = take_r ? b_key : a_key;
  assign c_handle = take_r ? b_handle : a_handle;
  assign c_data   = take_r ? ent_rd_data_b : ent_rd_data_a;
  assign c_addr   = take_r ? c_right[SW-1:0] : c_left[SW-1:0];

  assign unit_op = (mode_q == MODE_DECREASE) ? KOP_DECREASE : KOP_LOAD;

  imhdk_key_unit #(
    .KEY_BITS (KEY_BITS)
  ) u_key (
    .op         (unit_op),
    .key_in     (key_q),
    .amount     (amt_q),
    .stored_key (a_key),
    .new_key    (unit_key)
  );

  imhdk_entry_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW),
    .AW    (SW)
  ) u_entries (
    .clk       (clk),
    .we        (ent_we),
    .wr_addr   (ent_wr_addr),
    .wr_data   (ent_wr_data),
    .rd_en     (ent_rd_en),
    .rd_addr_a (ent_rd_addr_a),
    .rd_addr_b (ent_rd_addr_b),
    .rd_data_a (ent_rd_data_a),
    .rd_data_b (ent_rd_data_b)
  );

  imhdk_map_ram #(
    .DEPTH (HANDLE_COUNT),
    .WIDTH (SW),
    .AW    (HW)
  ) u_map (
    .clk     (clk),
    .we      (map_we),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_en   (map_rd_en),
    .rd_addr (HW'(req.handle)),
    .rd_data (map_rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (req.mode)
            MODE_INSERT:   state_next = (occ >= OW'(CAPACITY) || !h_ok) ? S_DONE : S_MAP;
            MODE_DECREASE: state_next = h_ok ? S_MAP : S_DONE;
            MODE_EXTRACT:  state_next = (occ > OW'(1)) ? S_LAST : S_DONE;
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_MAP:  state_next = S_LIVE;
      S_LIVE: begin
        if (mode_q == MODE_INSERT) begin
          state_next = live ? S_DONE : S_UP_RD;
        end else begin
          state_next = live ? S_UP_RD : S_DONE;
        end
      end
      S_LAST:   state_next = S_DN_RD;
      S_UP_RD:  state_next = (cur == '0) ? S_PLACE : S_UP_CMP;
      S_UP_CMP: state_next = (ek < a_key) ? S_UP_RD : S_PLACE;
      S_DN_RD:  state_next = (c_left < occ_x) ? S_DN_CMP : S_PLACE;
      S_DN_CMP: state_next = (ek > c_key) ? S_DN_RD : S_PLACE;
      S_PLACE:  state_next = S_DONE;
      S_DONE:   state_next = rsp_load ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory control per state.
  always_comb begin
    ent_we        = 1'b0;
    ent_wr_addr   = cur;
    ent_wr_data   = {ek, eh};
    ent_rd_en     = 1'b0;
    ent_rd_addr_a = '0;
    ent_rd_addr_b = '0;
    map_we        = 1'b0;
    map_wr_addr   = HW'(eh);
    map_wr_data   = cur;
    map_rd_en     = 1'b0;
    unique case (state)
      S_IDLE: begin
        map_rd_en = acc;
        if (acc && req.mode == MODE_EXTRACT) begin
          // Fetch the last entry; it moves to the root.
          ent_rd_en     = 1'b1;
          ent_rd_addr_a = SW'(occ - OW'(1));
        end
      end
      S_MAP: begin
        ent_rd_en     = 1'b1;
        ent_rd_addr_a = map_rd_data;
      end
      S_UP_RD: begin
        ent_rd_en     = (cur != '0);
        ent_rd_addr_a = parent;
      end
      S_UP_CMP: begin
        if (ek < a_key) begin
          // Drop the parent into the hole.
          ent_we      = 1'b1;
          ent_wr_data = ent_rd_data_a;
          map_we      = 1'b1;
          map_wr_addr = HW'(a_handle);
        end
      end
      S_DN_RD: begin
        ent_rd_en     = (c_left < occ_x);
        ent_rd_addr_a = c_left[SW-1:0];
        ent_rd_addr_b = c_right[SW-1:0];
      end
      S_DN_CMP: begin
        if (ek > c_key) begin
          // Lift the smaller child into the hole.
          ent_we      = 1'b1;
          ent_wr_data = c_data;
          map_we      = 1'b1;
          map_wr_addr = HW'(c_handle);
        end
      end
      S_PLACE: begin
        ent_we = 1'b1;
        map_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && acc && req.mode == MODE_EXTRACT && occ != '0) begin
        occ <= occ - OW'(1);
      end else if (state == S_LIVE && mode_q == MODE_INSERT && !live) begin
        occ <= occ + OW'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign root64 = 64'(root_key);

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      mode_q   <= req.mode;
      key_q    <= req.key_value;
      amt_q    <= req.decrease_amount;
      handle_q <= req.handle;
      stat     <= ST_OK;
      unique case (req.mode)
        MODE_INSERT: begin
          if (occ >= OW'(CAPACITY)) begin
            stat <= ST_FULL;
          end else if (!h_ok) begin
            stat <= ST_NOT_LIVE;
          end
        end
        MODE_DECREASE: begin
          if (!h_ok) begin
            stat <= ST_NOT_LIVE;
          end
        end
        default: begin
          if (occ == '0) begin
            stat <= ST_EMPTY;
          end
        end
      endcase
    end
    unique case (state)
      S_MAP: cur <= map_rd_data;
      S_LIVE: begin
        eh <= handle_q;
        ek <= unit_key;
        if (mode_q == MODE_INSERT) begin
          if (live) begin
            stat <= ST_NOT_LIVE;
          end else begin
            cur <= SW'(occ);
          end
        end else if (!live) begin
          stat <= ST_NOT_LIVE;
        end
      end
      S_LAST: begin
        ek  <= a_key;
        eh  <= a_handle;
        cur <= '0;
      end
      S_UP_CMP: begin
        if (ek < a_key) begin
          cur <= parent;
        end
      end
      S_DN_CMP: begin
        if (ek > c_key) begin
          cur <= c_addr;
        end
      end
      default: ;
    endcase
    // Track the root so the result needs no extra read.
    if (ent_we && ent_wr_addr == '0) begin
      root_key <= ent_wr_data[HANDLE_BITS +: KEY_BITS];
    end
    if (rsp_load) begin
      rsp.min_key     <= (occ == '0) ? '0 : root64[KEY_IN_BITS-1:0];
      rsp.entry_count <= COUNT_BITS'(occ);
      rsp.status      <= stat;
    end
  end

  // Heap never holds more than its capacity.
  assert property (@(posedge clk) disable iff (rst) occ <= OW'(CAPACITY))
    else $error("occupancy above capacity");

  // The moving hole always sits inside the occupied region while sifting.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_UP_RD || state == S_UP_CMP || state == S_DN_RD || state == S_DN_CMP ||
     state == S_PLACE) |-> (OW'(cur) < occ))
    else $error("sift position outside heap");

  // An empty-heap report carries a zero count and a zero key.
  assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> (rsp.status != ST_EMPTY) || (rsp.entry_count == '0 && rsp.min_key == '0))
    else $error("empty status with nonempty result");

  // A result with no entries reports a zero minimum.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.entry_count == '0) |-> (rsp.min_key == '0))
    else $error("nonzero minimum on empty heap");

endmodule

`default_nettype wire
